@@ hdl/assert_macros.svh @@
// assertion macros for the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CMF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define CMF_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/cmf_pkg.sv @@
// types and constants for the can message dle framer
package cmf_pkg;

    localparam int MAX_FRAMES = 32;

    localparam logic [7:0] DLE_BYTE      = 8'h10;
    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] ETX_BYTE      = 8'h03;
    localparam logic [7:0] RAW_TYPE      = 8'h95;
    localparam logic [7:0] SEQ_MARK      = 8'h20;
    localparam logic [7:0] PAD_BYTE      = 8'hff;
    localparam logic [7:0] FRAME_PAYLOAD = 8'd8;
    localparam logic [7:0] HDR_LEN       = 8'd6;
    localparam logic [7:0] SPLIT_CAP     = 8'(6 + 7 * (MAX_FRAMES - 1));

    localparam int FN_W   = 5;
    localparam int SLOT_W = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [28:0] can_identifier;
        logic [15:0] time_stamp;
        logic [7:0]  message_length;
        logic [7:0]  data_value;
        logic        data_present;
        logic        fast_request;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_value;
        logic       frame_done;
        logic       run_last;
    } out_item_t;

    // one command for the byte serializer: which frame parts to emit
    typedef struct packed {
        logic              open;
        logic [7:0]        frame_len;
        logic              cnt_en;
        logic [7:0]        cnt_byte;
        logic              len_en;
        logic [7:0]        len_byte;
        logic              data_en;
        logic [7:0]        data;
        logic [SLOT_W-1:0] pad_cnt;
        logic              close;
        logic [28:0]       id;
        logic [15:0]       ts;
    } cmd_t;

endpackage

@@ hdl/cmf_queue.sv @@
// command queue between the classifier and the byte serializer
`include "assert_macros.svh"

module cmf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output cmf_pkg::cmd_t head,
    output logic          head_valid,
    output logic          full
);
    import cmf_pkg::*;

    localparam logic [QUEUE_AW:0] COUNT_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == COUNT_FULL);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CMF_ASSERT(a_no_push_when_full, push |-> (count_reg != COUNT_FULL), "push into full queue")
    `CMF_ASSERT(a_no_pop_when_empty, pop |-> (count_reg != '0), "pop from empty queue")
    `CMF_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_reg <= COUNT_FULL), "queue count out of range")

endmodule

@@ hdl/cmf_front.sv @@
// front end: accepts items, tracks message state and issues frame commands
module cmf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  cmf_pkg::in_item_t item,
    input  logic              queue_full,
    output logic              push,
    output cmf_pkg::cmd_t     push_cmd
);
    import cmf_pkg::*;

    logic [7:0]        bytes_taken_reg, bytes_taken_next;
    logic [FN_W-1:0]   frame_number_reg, frame_number_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              split_reg, split_next;
    logic              mid_reg, mid_next;

    logic              start;
    logic              split_eff;
    logic [7:0]        bt;
    logic [FN_W-1:0]   fn;
    logic [SLOT_W-1:0] slot;
    logic              drop;
    logic [7:0]        len_sat;
    logic              opening;
    logic [SLOT_W-1:0] slot_open;
    logic [SLOT_W-1:0] slot_after;
    logic [7:0]        bt1;
    logic              msg_end;
    logic              frame_full;

    always_comb
    begin
        start     = !mid_reg;
        split_eff = start ? ((item.message_length > FRAME_PAYLOAD) || item.fast_request)
                          : split_reg;
        bt        = start ? '0 : bytes_taken_reg;
        fn        = start ? '0 : frame_number_reg;
        slot      = start ? '0 : slot_reg;

        drop = (item.can_identifier == '0)
            || (start && (item.data_present ? (item.message_length == '0)
                                            : (item.message_length != '0)))
            || (!start && !item.data_present);

        if (split_eff)
        begin
            len_sat = (item.message_length > SPLIT_CAP) ? SPLIT_CAP : item.message_length;
        end
        else
        begin
            len_sat = (item.message_length > FRAME_PAYLOAD) ? FRAME_PAYLOAD
                                                           : item.message_length;
        end

        opening = !item.data_present || (slot == '0);
        // counter byte, plus total length in the first frame
        if (opening && split_eff)
        begin
            slot_open = (fn == '0) ? SLOT_W'(2) : SLOT_W'(1);
        end
        else
        begin
            slot_open = slot;
        end
        slot_after = slot_open + SLOT_W'(item.data_present);
        bt1        = bt + 8'd1;
        msg_end    = (bt1 >= len_sat);
        frame_full = (slot_after >= SLOT_W'(FRAME_PAYLOAD));

        push_cmd.open      = opening;
        push_cmd.frame_len = split_eff ? (HDR_LEN + FRAME_PAYLOAD) : (HDR_LEN + len_sat);
        push_cmd.cnt_en    = split_eff && opening;
        push_cmd.cnt_byte  = SEQ_MARK | 8'(fn);
        push_cmd.len_en    = split_eff && opening && (fn == '0);
        push_cmd.len_byte  = len_sat;
        push_cmd.data_en   = item.data_present;
        push_cmd.data      = item.data_value;
        push_cmd.pad_cnt   = (split_eff && (!item.data_present || msg_end))
                           ? SLOT_W'(FRAME_PAYLOAD) - slot_after : '0;
        push_cmd.close     = !item.data_present || msg_end || frame_full;
        push_cmd.id        = item.can_identifier;
        push_cmd.ts        = item.time_stamp;

        push = item_valid && !queue_full && !drop;

        bytes_taken_next  = bytes_taken_reg;
        frame_number_next = frame_number_reg;
        slot_next         = slot_reg;
        split_next        = split_reg;
        mid_next          = mid_reg;
        if (push)
        begin
            split_next = split_eff;
            if (!item.data_present || msg_end)
            begin
                bytes_taken_next  = '0;
                frame_number_next = '0;
                slot_next         = '0;
                mid_next          = 1'b0;
            end
            else if (frame_full)
            begin
                bytes_taken_next  = bt1;
                frame_number_next = fn + 1'b1;
                slot_next         = '0;
                mid_next          = 1'b1;
            end
            else
            begin
                bytes_taken_next  = bt1;
                frame_number_next = fn;
                slot_next         = slot_after;
                mid_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg  <= '0;
            frame_number_reg <= '0;
            slot_reg         <= '0;
            split_reg        <= 1'b0;
            mid_reg          <= 1'b0;
        end
        else
        begin
            bytes_taken_reg  <= bytes_taken_next;
            frame_number_reg <= frame_number_next;
            slot_reg         <= slot_next;
            split_reg        <= split_next;
            mid_reg          <= mid_next;
        end
    end

endmodule

@@ hdl/cmf_back.sv @@
// back end: walks each command byte by byte with checksum and dle stuffing
module cmf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cmf_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output cmf_pkg::out_item_t result
);
    import cmf_pkg::*;

    localparam int PH_W   = 5;
    localparam int PH_NUM = 17;

    localparam logic [PH_W-1:0] PH_DLE0 = 5'd0;
    localparam logic [PH_W-1:0] PH_STX  = 5'd1;
    localparam logic [PH_W-1:0] PH_TYPE = 5'd2;
    localparam logic [PH_W-1:0] PH_LENF = 5'd3;
    localparam logic [PH_W-1:0] PH_TS0  = 5'd4;
    localparam logic [PH_W-1:0] PH_TS1  = 5'd5;
    localparam logic [PH_W-1:0] PH_ID0  = 5'd6;
    localparam logic [PH_W-1:0] PH_ID1  = 5'd7;
    localparam logic [PH_W-1:0] PH_ID2  = 5'd8;
    localparam logic [PH_W-1:0] PH_ID3  = 5'd9;
    localparam logic [PH_W-1:0] PH_CNT  = 5'd10;
    localparam logic [PH_W-1:0] PH_LENB = 5'd11;
    localparam logic [PH_W-1:0] PH_DATA = 5'd12;
    localparam logic [PH_W-1:0] PH_PAD  = 5'd13;
    localparam logic [PH_W-1:0] PH_CS   = 5'd14;
    localparam logic [PH_W-1:0] PH_DLE1 = 5'd15;
    localparam logic [PH_W-1:0] PH_ETX  = 5'd16;

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              dup_reg, dup_next;
    logic [SLOT_W-1:0] pad_left_reg, pad_left_next;
    logic [7:0]        sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [PH_W-1:0]   cur;
    logic [SLOT_W-1:0] pad_cur;
    logic [7:0]        byte_val;
    logic              counted;
    logic              need_dup;
    logic              stay_pad;
    logic [PH_NUM-1:0] en;
    logic              found;
    logic [PH_W-1:0]   nxt;
    logic              last;
    logic              go;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        cur     = busy_reg ? phase_reg : (cmd.open ? PH_DLE0 : PH_DATA);
        pad_cur = busy_reg ? pad_left_reg : cmd.pad_cnt;

        unique case (cur)
            PH_DLE0: byte_val = DLE_BYTE;
            PH_STX:  byte_val = STX_BYTE;
            PH_TYPE: byte_val = RAW_TYPE;
            PH_LENF: byte_val = cmd.frame_len;
            PH_TS0:  byte_val = cmd.ts[7:0];
            PH_TS1:  byte_val = cmd.ts[15:8];
            PH_ID0:  byte_val = cmd.id[7:0];
            PH_ID1:  byte_val = cmd.id[15:8];
            PH_ID2:  byte_val = cmd.id[23:16];
            PH_ID3:  byte_val = {3'b000, cmd.id[28:24]};
            PH_CNT:  byte_val = cmd.cnt_byte;
            PH_LENB: byte_val = cmd.len_byte;
            PH_DATA: byte_val = cmd.data;
            PH_PAD:  byte_val = PAD_BYTE;
            PH_CS:   byte_val = 8'd0 - sum_reg;
            PH_DLE1: byte_val = DLE_BYTE;
            PH_ETX:  byte_val = ETX_BYTE;
            default: byte_val = DLE_BYTE;
        endcase

        counted  = (cur >= PH_TYPE) && (cur <= PH_PAD);
        need_dup = (counted || (cur == PH_CS)) && (byte_val == DLE_BYTE) && !dup_reg;
        stay_pad = (cur == PH_PAD) && (pad_cur > SLOT_W'(1));

        en          = '0;
        en[PH_DLE0] = cmd.open;
        en[PH_STX]  = cmd.open;
        en[PH_TYPE] = cmd.open;
        en[PH_LENF] = cmd.open;
        en[PH_TS0]  = cmd.open;
        en[PH_TS1]  = cmd.open;
        en[PH_ID0]  = cmd.open;
        en[PH_ID1]  = cmd.open;
        en[PH_ID2]  = cmd.open;
        en[PH_ID3]  = cmd.open;
        en[PH_CNT]  = cmd.cnt_en;
        en[PH_LENB] = cmd.len_en;
        en[PH_DATA] = cmd.data_en;
        en[PH_PAD]  = (cmd.pad_cnt != '0);
        en[PH_CS]   = cmd.close;
        en[PH_DLE1] = cmd.close;
        en[PH_ETX]  = cmd.close;

        // first enabled part after the current one
        found = 1'b0;
        nxt   = cur;
        for (int p = 0; p < PH_NUM; p++)
        begin
            if (!found && (PH_W'(p) > cur) && en[p])
            begin
                found = 1'b1;
                nxt   = PH_W'(p);
            end
        end

        last    = !need_dup && !stay_pad && !found;
        go      = cmd_valid && (!out_valid_reg || !result_stall);
        cmd_pop = go && last;

        phase_next     = phase_reg;
        busy_next      = busy_reg;
        dup_next       = dup_reg;
        pad_left_next  = pad_left_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (go)
        begin
            out_valid_next      = 1'b1;
            out_next.out_value  = byte_val;
            out_next.frame_done = (cur == PH_ETX);
            out_next.run_last   = last;

            if (cur == PH_DLE0)
            begin
                sum_next = '0;
            end
            else if (counted && !dup_reg)
            begin
                sum_next = sum_reg + byte_val;
            end

            busy_next     = !last;
            dup_next      = need_dup;
            phase_next    = (need_dup || stay_pad) ? cur : nxt;
            pad_left_next = (cur == PH_PAD) ? pad_cur - 1'b1 : pad_cur;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        pad_left_reg <= pad_left_next;
        sum_reg      <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DLE0;
            busy_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/can_message_dle_framer.sv @@
// Frames CAN messages into a DLE STX ... DLE ETX byte stream with checksum and
// DLE stuffing. An input item is classified in the cycle it is accepted and is
// queued as a frame command in a four-entry queue; the serializer reads the
// queue head and registers each output byte. While the output is not stalled it
// puts out one stuffed byte per cycle; an item produces one or two bytes for a
// data byte inside a frame and at most twenty-nine for a byte that opens and
// closes a frame. Items are accepted back to back until the command queue is
// full; sustained throughput is set by the serializer. No clearing pass is
// needed after reset.
module can_message_dle_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cmf_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output cmf_pkg::out_item_t result
);
    import cmf_pkg::*;

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic head_valid;

    assign item_stall = queue_full;

    cmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    cmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head),
        .cmd_valid    (head_valid),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ tb/sv/tb_can_message_dle_framer.sv @@
// self-checking testbench for the can message dle framer
`timescale 1ns / 1ps

module tb_can_message_dle_framer;
    import cmf_pkg::*;

    localparam int LONG_HOLD = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    can_message_dle_framer uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    in_item_t  send_q[$];
    out_item_t expected_q[$];

    // framer state mirror
    logic [7:0] bytes_seen = '0;
    logic [4:0] frame_idx = '0;
    logic [3:0] slot_idx = '0;
    logic [7:0] frame_sum = '0;
    logic       split_on = 1'b0;
    logic       in_message = 1'b0;

    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    int          hold_ticket = 0;
    int          hold_served = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;

    int items_taken = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int mismatches = 0;
    int stim_items = 0;

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic put_out(logic [7:0] v, logic done);
        out_item_t r;
        r.out_value = v;
        r.frame_done = done;
        r.run_last = 1'b0;
        expected_q.push_back(r);
    endtask

    // counted byte: summed once, doubled on the wire when it equals DLE
    task automatic put_summed(logic [7:0] v);
        frame_sum = frame_sum + v;
        put_out(v, 1'b0);
        if (v == DLE_BYTE)
            put_out(v, 1'b0);
    endtask

    task automatic start_frame(in_item_t it, logic [7:0] payload_len);
        frame_sum = '0;
        put_out(DLE_BYTE, 1'b0);
        put_out(STX_BYTE, 1'b0);
        put_summed(RAW_TYPE);
        put_summed(HDR_LEN + payload_len);
        put_summed(it.time_stamp[7:0]);
        put_summed(it.time_stamp[15:8]);
        put_summed(it.can_identifier[7:0]);
        put_summed(it.can_identifier[15:8]);
        put_summed(it.can_identifier[23:16]);
        put_summed({3'b000, it.can_identifier[28:24]});
    endtask

    task automatic end_frame();
        logic [7:0] check;
        check = 8'h00 - frame_sum;
        put_out(check, 1'b0);
        if (check == DLE_BYTE)
            put_out(check, 1'b0);
        put_out(DLE_BYTE, 1'b0);
        put_out(ETX_BYTE, 1'b1);
        frame_sum = '0;
    endtask

    // expected byte stream for one accepted transfer
    task automatic frame_bytes_for(in_item_t it);
        logic [7:0] eff_len;
        out_item_t  tail;
        if (it.can_identifier == '0)
            return;
        if (!in_message)
        begin
            if (it.data_present ? (it.message_length == 0) : (it.message_length != 0))
                return;
            split_on = (it.message_length > FRAME_PAYLOAD) || it.fast_request;
            bytes_seen = '0;
            frame_idx = '0;
            slot_idx = '0;
        end
        else if (!it.data_present)
            return;

        eff_len = it.message_length;
        if (split_on && eff_len > SPLIT_CAP)
            eff_len = SPLIT_CAP;
        else if (!split_on && eff_len > FRAME_PAYLOAD)
            eff_len = FRAME_PAYLOAD;

        if (!it.data_present)
        begin
            if (split_on)
            begin
                start_frame(it, FRAME_PAYLOAD);
                put_summed(SEQ_MARK);
                put_summed(8'h00);
                repeat (6) put_summed(PAD_BYTE);
            end
            else
                start_frame(it, 8'h00);
            end_frame();
        end
        else
        begin
            if (slot_idx == 0)
            begin
                if (split_on)
                begin
                    start_frame(it, FRAME_PAYLOAD);
                    put_summed(SEQ_MARK | {3'b000, frame_idx});
                    slot_idx = 1;
                    if (frame_idx == 0)
                    begin
                        put_summed(eff_len);
                        slot_idx = 2;
                    end
                end
                else
                    start_frame(it, eff_len);
            end
            put_summed(it.data_value);
            slot_idx++;
            bytes_seen++;
            in_message = 1'b1;
            if (bytes_seen >= eff_len)
            begin
                if (split_on)
                begin
                    while (slot_idx < FRAME_PAYLOAD)
                    begin
                        put_summed(PAD_BYTE);
                        slot_idx++;
                    end
                end
                end_frame();
                in_message = 1'b0;
                bytes_seen = '0;
                frame_idx = '0;
                slot_idx = '0;
            end
            else if (slot_idx >= FRAME_PAYLOAD)
            begin
                end_frame();
                frame_idx++;
                slot_idx = '0;
            end
        end
        tail = expected_q.pop_back();
        tail.run_last = 1'b1;
        expected_q.push_back(tail);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            tx_wait <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
            begin
                frame_bytes_for(item);
                items_taken++;
            end
            if (tx_wait != 0)
            begin
                item_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end
            else if (send_q.size() != 0)
            begin
                item <= send_q.pop_front();
                item_valid <= 1'b1;
                tx_wait <= tx_idle ? $urandom_range(0, 15) : 0;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver stall: per-transfer pause, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int unsigned pause;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
        end
        else if (hold_served != hold_ticket)
        begin
            hold_served <= hold_ticket;
            hold_left <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (result_valid && !result_stall)
        begin
            pause = rx_idle ? $urandom_range(0, 15) : 0;
            result_stall <= (pause != 0);
            rx_wait <= (pause == 0) ? 0 : pause - 1;
        end
        else if (rx_wait != 0)
        begin
            rx_wait <= rx_wait - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (result.frame_done)
                frames_seen++;
            if (expected_q.size() == 0)
                flag_error($sformatf("unexpected result %0d: %h done=%b last=%b",
                                     results_seen, result.out_value, result.frame_done,
                                     result.run_last));
            else
            begin
                want = expected_q.pop_front();
                if (result.out_value !== want.out_value
                        || result.frame_done !== want.frame_done
                        || result.run_last !== want.run_last)
                    flag_error($sformatf(
                        "mismatch at result %0d: expected %h/%b/%b, got %h/%b/%b",
                        results_seen, want.out_value, want.frame_done, want.run_last,
                        result.out_value, result.frame_done, result.run_last));
            end
        end
    end

    function automatic in_item_t make_item(logic [28:0] id, logic [15:0] ts, logic [7:0] len,
                                           logic [7:0] data, logic present, logic fast);
        in_item_t it;
        it.can_identifier = id;
        it.time_stamp = ts;
        it.message_length = len;
        it.data_value = data;
        it.data_present = present;
        it.fast_request = fast;
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1:    return DLE_BYTE;
            2:       return 8'hff;
            3:       return 8'h00;
            default: return 8'($urandom());
        endcase
    endfunction

    // message bytes, with the odd dropped or stray item mixed in
    task automatic add_message(logic [28:0] id, logic [15:0] ts, logic [7:0] len,
                               logic fast, int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_q.push_back(make_item('0, ts, len, pick_byte(), 1'b1, fast));
                else
                    send_q.push_back(make_item(id, ts, 8'($urandom()), pick_byte(), 1'b0, fast));
            end
            send_q.push_back(make_item(id, ts, len, pick_byte(), 1'b1, fast));
            stim_items++;
        end
    endtask

    task automatic wait_drained();
        while (send_q.size() != 0 || item_valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0]  raw_bytes [8] = '{8'h00, 8'hff, 8'h10, 8'h10, 8'h01, 8'h80, 8'h7f, 8'hfe};
        logic [28:0] id;
        logic [15:0] ts;
        logic [7:0]  len;
        logic [7:0]  sum8;
        logic        fast;
        int          kind;
        int          cut;
        int          phase_start;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, no idling on either side
        send_q.push_back(make_item('0, 16'h5555, 8'd1, 8'haa, 1'b1, 1'b0));
        send_q.push_back(make_item(29'h1fffffff, 16'hffff, 8'd0, 8'h00, 1'b0, 1'b0));
        send_q.push_back(make_item(29'h10101010, 16'h1010, 8'd0, 8'hff, 1'b0, 1'b1));
        // ignored: a byte with zero length, an empty item with a length
        send_q.push_back(make_item(29'h1, 16'h0000, 8'd0, 8'h10, 1'b1, 1'b0));
        send_q.push_back(make_item(29'h2, 16'h0000, 8'd3, 8'h10, 1'b0, 1'b0));
        for (int k = 0; k < 8; k++)
        begin
            if (k == 3)
                send_q.push_back(make_item(29'h10, 16'h0010, 8'd8, 8'h00, 1'b0, 1'b0));
            if (k == 5)
                send_q.push_back(make_item('0, 16'h0010, 8'd8, 8'h10, 1'b1, 1'b0));
            send_q.push_back(make_item(29'h10, 16'h0010, 8'd8, raw_bytes[k], 1'b1, 1'b0));
        end
        // one byte forced into fast-packet, padded frame 0
        send_q.push_back(make_item(29'h0000100, 16'h8000, 8'd1, 8'h10, 1'b1, 1'b1));
        // data byte picked so that the checksum comes out as DLE
        id = 29'h0abcdef;
        ts = 16'h1234;
        sum8 = RAW_TYPE + HDR_LEN + 8'd1 + ts[7:0] + ts[15:8] + id[7:0] + id[15:8]
               + id[23:16] + {3'b000, id[28:24]};
        send_q.push_back(make_item(id, ts, 8'd1, 8'hf0 - sum8, 1'b1, 1'b0));
        // length over capacity, then cut short by a smaller length
        for (int k = 0; k < 7; k++)
            send_q.push_back(make_item(29'h1555aaaa, 16'h0f0f, 8'd255, pick_byte(), 1'b1, 1'b0));
        send_q.push_back(make_item(29'h1555aaaa, 16'h0f0f, 8'd3, 8'h55, 1'b1, 1'b0));
        wait_drained();

        for (int phase = 1; phase <= 5; phase++)
        begin
            tx_idle = (phase == 2 || phase == 4);
            rx_idle = (phase == 1 || phase == 2 || phase == 5);
            // receiver holds off while the sender keeps offering
            if (phase == 1)
                hold_ticket <= hold_ticket + 1;
            if (phase == 3)
                add_message(29'($urandom()), 16'($urandom()), 8'd223, 1'b0, 223);
            phase_start = stim_items;
            while (stim_items - phase_start < 30)
            begin
                kind = $urandom_range(0, 99);
                id = 29'($urandom());
                ts = 16'($urandom());
                fast = 1'($urandom_range(0, 1));
                if (kind < 5)
                begin
                    send_q.push_back(make_item(id, ts, 8'd0, pick_byte(), 1'b0, fast));
                    stim_items++;
                end
                else if (kind < 50)
                begin
                    len = 8'($urandom_range(1, 8));
                    add_message(id, ts, len, fast, len);
                end
                else if (kind < 85)
                begin
                    len = 8'($urandom_range(9, 40));
                    add_message(id, ts, len, fast, len);
                end
                else if (kind < 90)
                begin
                    // length changes partway through the message
                    len = 8'($urandom_range(1, 255));
                    cut = $urandom_range(1, (len < 12) ? len : 12);
                    add_message(id, ts, len, fast, cut);
                    add_message(id, ts, 8'($urandom()), fast, $urandom_range(1, 10));
                end
                else if (kind < 95)
                begin
                    // truncated message, the next one runs into it
                    len = 8'($urandom_range(2, 40));
                    add_message(id, ts, len, fast, $urandom_range(1, len - 1));
                end
                else
                    send_q.push_back(make_item($urandom_range(0, 1) ? id : 29'h0, ts,
                                               8'($urandom()), pick_byte(),
                                               1'($urandom_range(0, 1)), fast));
            end
            wait_drained();
        end

        repeat (64) @(posedge clk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", expected_q.size()));
        $display("covered %0d input transfers, %0d output bytes in %0d frames",
                 items_taken, results_seen, frames_seen);
        $display("raw, fast-packet, empty, oversize and broken messages; long output hold");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
